@@ rtl/dmrps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrps_pkg: shared types and constants
// Command codes, packet layout, work descriptor and speed helpers for the
// dual motor ramp packet sequencer.
// ----------------------------------------------------------------------------
package dmrps_pkg;

	// command codes
	localparam logic [3:0] CMD_STOP      = 4'd0;
	localparam logic [3:0] CMD_FWD       = 4'd1;
	localparam logic [3:0] CMD_REV       = 4'd2;
	localparam logic [3:0] CMD_SPIN_L    = 4'd3;
	localparam logic [3:0] CMD_SPIN_R    = 4'd4;
	localparam logic [3:0] CMD_FWD_L     = 4'd5;
	localparam logic [3:0] CMD_FWD_R     = 4'd6;
	localparam logic [3:0] CMD_REV_L     = 4'd7;
	localparam logic [3:0] CMD_REV_R     = 4'd8;
	localparam logic [3:0] CMD_FASTER    = 4'd9;
	localparam logic [3:0] CMD_SLOWER    = 4'd10;
	localparam logic [3:0] CMD_RESET_SPD = 4'd11;

	// motion codes
	localparam logic [1:0] ACT_STOP = 2'd0;
	localparam logic [1:0] ACT_FWD  = 2'd1;
	localparam logic [1:0] ACT_REV  = 2'd2;
	localparam logic [1:0] ACT_TURN = 2'd3;

	// register indexes and address width
	localparam int         ADDR_W   = 4;
	localparam logic [1:0] REG_SPIN = 2'd0;
	localparam logic [1:0] REG_TURN = 2'd1;
	localparam logic [1:0] REG_DEF  = 2'd2;

	localparam logic [7:0] SPIN_RST = 8'd40;
	localparam logic [7:0] TURN_RST = 8'd20;
	localparam logic [7:0] DEF_RST  = 8'd30;

	// packet constants
	localparam logic [7:0] HEADER_VALUE  = 8'd85;
	localparam logic [7:0] LEFT_CHANNEL  = 8'd0;
	localparam logic [7:0] RIGHT_CHANNEL = 8'd8;
	localparam logic [7:0] REST_VALUE    = 8'd127;
	localparam logic [7:0] SPEED_STEP    = 8'd10;
	localparam logic [7:0] SPEED_MAX     = 8'd255;

	// ramp constants
	localparam logic signed [9:0] START_STEP  = 10'sd5;
	localparam logic signed [9:0] STOP_STEP   = 10'sd10;
	localparam logic [4:0]        START_STEPS = 5'd20;
	localparam logic [4:0]        STOP_STEPS  = 5'd10;
	localparam logic [6:0]        START_PAUSE = 7'd50;
	localparam logic [6:0]        STOP_PAUSE  = 7'd100;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		RAMP_NONE  = 2'd0,
		RAMP_START = 2'd1,
		RAMP_STOP  = 2'd2
	} ramp_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic       smooth;
	} cmd_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] channel_byte;
		logic [7:0] speed_byte;
		logic [7:0] check_byte;
		logic [6:0] pause_ms;
		logic       last;
	} pkt_t;

	// one unit of work for the back end
	typedef struct packed {
		ramp_t      ramp;
		logic       neg;
		logic [7:0] limit;
		logic [7:0] final_left;
		logic [7:0] final_right;
	} job_t;

	// clamp a signed drive value to a byte
	function automatic logic [7:0] clamp_speed(input logic signed [10:0] v);
		logic [7:0] r;
		if (v < 11'sd0) begin
			r = 8'd0;
		end else if (v > 11'sd255) begin
			r = SPEED_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/dmrps_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrps_front: command decoder
// Keeps motion and speed state, turns each command into a job descriptor.
// ----------------------------------------------------------------------------
module dmrps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  dmrps_pkg::cmd_t     command,
	input  logic [7:0]          spin_speed,
	input  logic [7:0]          turn_offset,
	input  logic [7:0]          reload_speed,
	output logic                job_valid,
	output dmrps_pkg::job_t     job
);
	import dmrps_pkg::*;

	logic [1:0] cur_q;
	logic [1:0] straight_q;
	logic [7:0] speed_q;

	logic [8:0]         faster_sum;
	logic [7:0]         new_speed;
	logic signed [10:0] rest_s;
	logic signed [10:0] spd_s;
	logic signed [10:0] spin_s;
	logic signed [10:0] turn_s;
	logic [7:0]         fwd_val;
	logic [7:0]         rev_val;
	logic               moving;

	// next speed for the speed commands
	assign faster_sum = {1'b0, speed_q} + {1'b0, SPEED_STEP};
	always_comb begin
		case (command.cmd)
			CMD_FASTER:    new_speed = faster_sum[8] ? SPEED_MAX : faster_sum[7:0];
			CMD_SLOWER:    new_speed = (speed_q < SPEED_STEP) ? 8'd0 : speed_q - SPEED_STEP;
			CMD_RESET_SPD: new_speed = reload_speed;
			default:       new_speed = speed_q;
		endcase
	end

	// drive values
	assign rest_s  = signed'({3'b000, REST_VALUE});
	assign spd_s   = signed'({3'b000, new_speed});
	assign spin_s  = signed'({3'b000, spin_speed});
	assign turn_s  = signed'({3'b000, turn_offset});
	assign fwd_val = clamp_speed(rest_s + spd_s);
	assign rev_val = clamp_speed(rest_s - spd_s);
	assign moving  = (cur_q == ACT_FWD) || (cur_q == ACT_REV);

	// job descriptor
	always_comb begin
		job_valid       = 1'b0;
		job.ramp        = RAMP_NONE;
		job.neg         = 1'b0;
		job.limit       = speed_q;
		job.final_left  = REST_VALUE;
		job.final_right = REST_VALUE;
		case (command.cmd)
			CMD_STOP: begin
				job_valid = 1'b1;
				job.ramp  = ((straight_q == ACT_FWD) || (straight_q == ACT_REV)) ?
					RAMP_STOP : RAMP_NONE;
				job.neg   = (straight_q == ACT_REV);
			end
			CMD_FWD: begin
				job_valid       = 1'b1;
				job.ramp        = command.smooth ? RAMP_START : RAMP_NONE;
				job.final_left  = fwd_val;
				job.final_right = fwd_val;
			end
			CMD_REV: begin
				job_valid       = 1'b1;
				job.ramp        = command.smooth ? RAMP_START : RAMP_NONE;
				job.neg         = 1'b1;
				job.final_left  = rev_val;
				job.final_right = rev_val;
			end
			CMD_SPIN_L: begin
				job_valid       = 1'b1;
				job.final_left  = clamp_speed(rest_s - spin_s);
				job.final_right = clamp_speed(rest_s + spin_s);
			end
			CMD_SPIN_R: begin
				job_valid       = 1'b1;
				job.final_left  = clamp_speed(rest_s + spin_s);
				job.final_right = clamp_speed(rest_s - spin_s);
			end
			CMD_FWD_L: begin
				job_valid       = 1'b1;
				job.final_left  = fwd_val;
				job.final_right = clamp_speed(rest_s + spd_s + turn_s);
			end
			CMD_FWD_R: begin
				job_valid       = 1'b1;
				job.final_left  = clamp_speed(rest_s + spd_s + turn_s);
				job.final_right = fwd_val;
			end
			CMD_REV_L: begin
				job_valid       = 1'b1;
				job.final_left  = rev_val;
				job.final_right = clamp_speed(rest_s - spd_s - turn_s);
			end
			CMD_REV_R: begin
				job_valid       = 1'b1;
				job.final_left  = clamp_speed(rest_s - spd_s - turn_s);
				job.final_right = rev_val;
			end
			CMD_FASTER, CMD_SLOWER, CMD_RESET_SPD: begin
				job_valid       = moving;
				job.neg         = (cur_q == ACT_REV);
				job.final_left  = (cur_q == ACT_REV) ? rev_val : fwd_val;
				job.final_right = (cur_q == ACT_REV) ? rev_val : fwd_val;
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	// motion and speed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= ACT_STOP;
			straight_q <= ACT_STOP;
			speed_q    <= DEF_RST;
		end else if (accept) begin
			if (command.cmd == CMD_STOP) begin
				cur_q      <= ACT_STOP;
				straight_q <= ACT_STOP;
			end else if (command.cmd == CMD_FWD) begin
				cur_q      <= ACT_FWD;
				straight_q <= ACT_FWD;
			end else if (command.cmd == CMD_REV) begin
				cur_q      <= ACT_REV;
				straight_q <= ACT_REV;
			end else if (command.cmd inside {CMD_SPIN_L, CMD_SPIN_R, CMD_FWD_L, CMD_FWD_R,
					CMD_REV_L, CMD_REV_R}) begin
				cur_q <= ACT_TURN;
			end else if (command.cmd inside {CMD_FASTER, CMD_SLOWER, CMD_RESET_SPD}) begin
				speed_q <= new_speed;
				if (moving) begin
					straight_q <= cur_q;
				end
			end
		end
	end

endmodule

@@ rtl/dmrps_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrps_queue: job queue
// Short first-in first-out store between the decoder and the packet engine.
// ----------------------------------------------------------------------------
module dmrps_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  dmrps_pkg::job_t  wr_job,
	input  logic             rd_en,
	output dmrps_pkg::job_t  rd_job,
	output logic             q_full,
	output logic             q_empty
);
	import dmrps_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/dmrps_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrps_back: packet engine
// Walks each job through its ramp steps and final pair into an output register,
// one packet a cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module dmrps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  dmrps_pkg::job_t  job,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output dmrps_pkg::pkt_t  packet
);
	import dmrps_pkg::*;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_RAMP  = 3'b010,
		BK_FINAL = 3'b100
	} bk_state_t;

	bk_state_t        state_q;
	job_t             job_q;
	logic             side_q;
	logic signed [9:0] step_q;
	logic [4:0]       cnt_q;
	pkt_t             out_q;
	logic             out_valid_q;

	logic               adv;
	logic               emit;
	logic signed [10:0] step_ext;
	logic signed [10:0] ramp_val;
	logic [7:0]         spd;
	logic [7:0]         chan;
	logic [4:0]         cnt_next;
	logic               more;

	assign adv   = !out_valid_q || pop;
	assign emit  = adv && ((state_q == BK_RAMP) || (state_q == BK_FINAL));
	assign q_pop = (state_q == BK_IDLE) && !q_empty;
	assign empty = !out_valid_q;
	assign packet = out_q;

	// ramp step drive value
	assign step_ext = {step_q[9], step_q};
	assign ramp_val = signed'({3'b000, REST_VALUE}) + (job_q.neg ? -step_ext : step_ext);

	always_comb begin
		if (state_q == BK_RAMP) begin
			spd = clamp_speed(ramp_val);
		end else begin
			spd = side_q ? job_q.final_right : job_q.final_left;
		end
	end
	assign chan = side_q ? RIGHT_CHANNEL : LEFT_CHANNEL;

	// does the ramp take another step
	assign cnt_next = cnt_q + 5'd1;
	always_comb begin
		if (job_q.ramp == RAMP_START) begin
			more = (step_q < signed'({2'b00, job_q.limit})) && (cnt_next < START_STEPS);
		end else begin
			more = (step_q > 10'sd0) && (cnt_next < STOP_STEPS);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			side_q  <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (!q_empty) begin
						side_q  <= 1'b0;
						state_q <= (job.ramp == RAMP_NONE) ? BK_FINAL : BK_RAMP;
					end
				end
				BK_RAMP: begin
					if (emit) begin
						side_q <= !side_q;
						if (side_q && !more) begin
							state_q <= BK_FINAL;
						end
					end
				end
				BK_FINAL: begin
					if (emit) begin
						side_q <= !side_q;
						if (side_q) begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// job registers and ramp step
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q  <= job;
			cnt_q  <= '0;
			step_q <= (job.ramp == RAMP_STOP) ?
				signed'({2'b00, job.limit}) - STOP_STEP : START_STEP;
		end else if (emit && (state_q == BK_RAMP) && side_q) begin
			cnt_q  <= cnt_next;
			step_q <= (job_q.ramp == RAMP_START) ? step_q + START_STEP : step_q - STOP_STEP;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.header_byte  <= HEADER_VALUE;
			out_q.channel_byte <= chan;
			out_q.speed_byte   <= spd;
			out_q.check_byte   <= HEADER_VALUE + chan + spd;
			out_q.pause_ms     <= ((state_q == BK_RAMP) && side_q) ?
				((job_q.ramp == RAMP_START) ? START_PAUSE : STOP_PAUSE) : 7'd0;
			out_q.last         <= (state_q == BK_FINAL) && side_q;
		end
	end

endmodule

@@ rtl/dual_motor_ramp_packet_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_ramp_packet_sequencer: two-motor drive packet sequencer
// Decodes drive commands and emits left/right motor packets with ramps.
// ----------------------------------------------------------------------------
// order: a command enters the job queue at its accepting edge; the packet
//   engine then loads it from the queue and registers its first packet
// throughput: one packet per cycle while pop is held, with the engine passing
//   through its idle state to load each command; a command gives up to 42 packets
// reset: motion stopped, speed 30, registers at 40/20/30, queue and output empty
module dual_motor_ramp_packet_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dmrps_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  dmrps_pkg::cmd_t                command,
	output logic                           empty,
	input  logic                           pop,
	output dmrps_pkg::pkt_t                packet
);
	import dmrps_pkg::*;

	logic [7:0] spin_q;
	logic [7:0] turn_q;
	logic [7:0] def_q;
	logic       cfg_wr;
	logic       accept;
	logic       job_valid;
	job_t       job_in;
	job_t       job_out;
	logic       q_pop;
	logic       q_empty;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_q <= SPIN_RST;
			turn_q <= TURN_RST;
			def_q  <= DEF_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SPIN: spin_q <= pwdata[7:0];
				REG_TURN: turn_q <= pwdata[7:0];
				REG_DEF:  def_q  <= pwdata[7:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SPIN: prdata = {24'd0, spin_q};
			REG_TURN: prdata = {24'd0, turn_q};
			REG_DEF:  prdata = {24'd0, def_q};
			default:  prdata = 32'd0;
		endcase
	end

	// command request handshake
	assign accept = push && !full;

	dmrps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.spin_speed   (spin_q),
		.turn_offset  (turn_q),
		.reload_speed (def_q),
		.job_valid    (job_valid),
		.job          (job_in)
	);

	dmrps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && job_valid),
		.wr_job (job_in),
		.rd_en  (q_pop),
		.rd_job (job_out),
		.q_full (full),
		.q_empty(q_empty)
	);

	dmrps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.job    (job_out),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.packet (packet)
	);

endmodule
